FILE: rtl/xsed_pkg.sv
// Shared types, codes and sizes for the cross-reference stream entry decoder.
// Used by every module under rtl/; depends on nothing.
package xsed_pkg;

  // Object slot table size and the address width of the filled-mark memory
  localparam int unsigned MAX_OBJECTS = 65536;
  localparam int unsigned MARK_AW     = $clog2(MAX_OBJECTS);

  // Field widths fixed by the stream format
  localparam int unsigned WID_W  = 3;
  localparam int unsigned TLEN_W = 17;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned ACC_W  = 32;

  // Input commands (code 3 is unused and ignored)
  typedef enum logic [1:0] {
    CMD_SECTION = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_END     = 2'd2
  } cmd_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ENTRY         = 3'd0,
    KIND_SECTION_OK    = 3'd1,
    KIND_SECTION_RANGE = 3'd2,
    KIND_STREAM_OK     = 3'd3,
    KIND_TRUNCATED     = 3'd4,
    KIND_ZERO_WIDTHS   = 3'd5
  } kind_t;

  // Mapped entry types
  typedef enum logic [1:0] {
    TYPE_FREE       = 2'd0,
    TYPE_IN_USE     = 2'd1,
    TYPE_COMPRESSED = 2'd2,
    TYPE_UNKNOWN    = 2'd3
  } etype_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TYPE_WIDTH   = 2'd0,
    REG_OFFSET_WIDTH = 2'd1,
    REG_GEN_WIDTH    = 2'd2,
    REG_TABLE_LENGTH = 2'd3
  } cfg_reg_t;

  // Field position inside an entry; field number 3 means entry complete
  localparam logic [1:0] FIELD_DONE = 2'd3;

  typedef struct packed {
    logic [WID_W-1:0]  type_w;
    logic [WID_W-1:0]  offset_w;
    logic [WID_W-1:0]  gen_w;
    logic [TLEN_W-1:0] tlen;
  } cfg_t;

  // One result word as it leaves the parser
  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    etype_t             etype;
    logic [ACC_W-1:0]   offset;
    logic [ACC_W-1:0]   gen;
    logic               in_range;
    logic [MARK_AW-1:0] mark_addr;
  } res_t;

  // Filled-mark update from the emit stage
  typedef struct packed {
    logic               en;
    logic [MARK_AW-1:0] addr;
  } mark_wr_t;

endpackage

FILE: rtl/xsed_cfg_regs.sv
// Configuration register file for the entry decoder.
// Depends on xsed_pkg.
module xsed_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_index,
  input  logic [xsed_pkg::TLEN_W-1:0]  wr_data,
  output xsed_pkg::cfg_t               cfg
);

  xsed_pkg::cfg_t cfg_r;

  // Write one register per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_w   <= xsed_pkg::WID_W'(1);
      cfg_r.offset_w <= xsed_pkg::WID_W'(4);
      cfg_r.gen_w    <= xsed_pkg::WID_W'(2);
      cfg_r.tlen     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        xsed_pkg::REG_TYPE_WIDTH:   cfg_r.type_w   <= wr_data[xsed_pkg::WID_W-1:0];
        xsed_pkg::REG_OFFSET_WIDTH: cfg_r.offset_w <= wr_data[xsed_pkg::WID_W-1:0];
        xsed_pkg::REG_GEN_WIDTH:    cfg_r.gen_w    <= wr_data[xsed_pkg::WID_W-1:0];
        xsed_pkg::REG_TABLE_LENGTH: cfg_r.tlen     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/xsed_parse.sv
// Input stage: section tracking, big-endian field gathering and entry completion.
// Depends on xsed_pkg.
module xsed_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  xsed_pkg::cfg_t               cfg,
  input  logic                         take,
  input  logic [1:0]                   cmd,
  input  logic [7:0]                   data_byte,
  input  logic [xsed_pkg::IDX_W-1:0]   first_index,
  input  logic [xsed_pkg::CNT_W-1:0]   entry_count,
  output logic                         res_valid,
  output xsed_pkg::res_t               res
);

  typedef struct packed {
    logic [1:0]               fn;
    logic [xsed_pkg::WID_W-1:0] bif;
  } fpos_t;

  logic [xsed_pkg::CNT_W-1:0]  cur_r, cur_nxt;
  logic [xsed_pkg::CNT_W-1:0]  left_r, left_nxt;
  logic [1:0]                  fn_r, fn_nxt;
  logic [xsed_pkg::WID_W-1:0]  bif_r, bif_nxt;
  logic [xsed_pkg::ACC_W-1:0]  ta_r, ta_nxt;
  logic [xsed_pkg::ACC_W-1:0]  oa_r, oa_nxt;
  logic [xsed_pkg::ACC_W-1:0]  ga_r, ga_nxt;

  logic [xsed_pkg::TLEN_W-1:0] eff_len;
  logic                        zero_w;
  logic [xsed_pkg::CNT_W:0]    sec_end;
  fpos_t                       pos;
  logic [xsed_pkg::ACC_W-1:0]  tval;
  logic                        emit;

  // Step past every field that already holds its configured byte count
  function automatic fpos_t skip_done(input fpos_t p, input xsed_pkg::cfg_t c);
    fpos_t q;
    q = p;
    if (q.fn == 2'd0 && c.type_w <= q.bif) begin
      q.fn  = 2'd1;
      q.bif = '0;
    end
    if (q.fn == 2'd1 && c.offset_w <= q.bif) begin
      q.fn  = 2'd2;
      q.bif = '0;
    end
    if (q.fn == 2'd2 && c.gen_w <= q.bif) begin
      q.fn  = xsed_pkg::FIELD_DONE;
      q.bif = '0;
    end
    return q;
  endfunction

  // Effective table length, capped at the slot table size
  always_comb begin
    if (32'(cfg.tlen) > xsed_pkg::MAX_OBJECTS) begin
      eff_len = xsed_pkg::TLEN_W'(xsed_pkg::MAX_OBJECTS);
    end else begin
      eff_len = cfg.tlen;
    end
  end

  assign zero_w  = (cfg.type_w == '0) && (cfg.offset_w == '0) && (cfg.gen_w == '0);
  assign sec_end = (xsed_pkg::CNT_W+1)'(first_index) + (xsed_pkg::CNT_W+1)'(entry_count);

  // Decode one word: next state and the result it causes
  always_comb begin
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    fn_nxt    = fn_r;
    bif_nxt   = bif_r;
    ta_nxt    = ta_r;
    oa_nxt    = oa_r;
    ga_nxt    = ga_r;
    res_valid = 1'b0;
    res       = '0;
    pos       = '{fn: fn_r, bif: bif_r};
    tval      = '0;
    emit      = 1'b0;

    case (cmd)
      xsed_pkg::CMD_SECTION: begin
        fn_nxt    = '0;
        bif_nxt   = '0;
        ta_nxt    = '0;
        oa_nxt    = '0;
        ga_nxt    = '0;
        left_nxt  = '0;
        res_valid = 1'b1;
        if (sec_end > (xsed_pkg::CNT_W+1)'(eff_len)) begin
          res.kind = xsed_pkg::KIND_SECTION_RANGE;
        end else begin
          cur_nxt = xsed_pkg::CNT_W'(first_index);
          if (zero_w) begin
            res.kind = xsed_pkg::KIND_ZERO_WIDTHS;
          end else begin
            left_nxt = entry_count;
            res.kind = xsed_pkg::KIND_SECTION_OK;
          end
        end
      end

      xsed_pkg::CMD_DATA: begin
        if (left_r != '0 && !zero_w) begin
          pos = skip_done(pos, cfg);
          if (pos.fn == xsed_pkg::FIELD_DONE) begin
            // no field left to take the byte: drop it and close the entry
            emit = 1'b1;
          end else begin
            case (pos.fn)
              2'd0:    ta_nxt = {ta_r[xsed_pkg::ACC_W-9:0], data_byte};
              2'd1:    oa_nxt = {oa_r[xsed_pkg::ACC_W-9:0], data_byte};
              default: ga_nxt = {ga_r[xsed_pkg::ACC_W-9:0], data_byte};
            endcase
            pos.bif = pos.bif + 1'b1;
            pos     = skip_done(pos, cfg);
            emit    = (pos.fn == xsed_pkg::FIELD_DONE);
          end

          if (emit) begin
            tval           = (cfg.type_w != '0) ? ta_nxt : xsed_pkg::ACC_W'(1);
            res_valid      = 1'b1;
            res.kind       = xsed_pkg::KIND_ENTRY;
            res.idx        = cur_r[xsed_pkg::IDX_W-1:0];
            res.etype      = (tval <= xsed_pkg::ACC_W'(2)) ? xsed_pkg::etype_t'(tval[1:0])
                                                           : xsed_pkg::TYPE_UNKNOWN;
            res.offset     = (cfg.offset_w != '0) ? oa_nxt : '0;
            res.gen        = (cfg.gen_w != '0) ? ga_nxt : '0;
            res.in_range   = (cur_r < eff_len) && (32'(cur_r) < xsed_pkg::MAX_OBJECTS);
            res.mark_addr  = xsed_pkg::MARK_AW'(cur_r);
            cur_nxt        = cur_r + 1'b1;
            left_nxt       = left_r - 1'b1;
            fn_nxt         = '0;
            bif_nxt        = '0;
            ta_nxt         = '0;
            oa_nxt         = '0;
            ga_nxt         = '0;
          end else begin
            fn_nxt  = pos.fn;
            bif_nxt = pos.bif;
          end
        end
      end

      xsed_pkg::CMD_END: begin
        res_valid = 1'b1;
        res.kind  = (left_r != '0) ? xsed_pkg::KIND_TRUNCATED : xsed_pkg::KIND_STREAM_OK;
        left_nxt  = '0;
        fn_nxt    = '0;
        bif_nxt   = '0;
        ta_nxt    = '0;
        oa_nxt    = '0;
        ga_nxt    = '0;
      end

      default: ;
    endcase
  end

  // Advance state on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      left_r <= '0;
      fn_r   <= '0;
      bif_r  <= '0;
      ta_r   <= '0;
      oa_r   <= '0;
      ga_r   <= '0;
    end else if (take) begin
      cur_r  <= cur_nxt;
      left_r <= left_nxt;
      fn_r   <= fn_nxt;
      bif_r  <= bif_nxt;
      ta_r   <= ta_nxt;
      oa_r   <= oa_nxt;
      ga_r   <= ga_nxt;
    end
  end

endmodule

FILE: rtl/xsed_marks.sv
// Filled-mark memory, one bit per object slot, with a clearing sweep after reset.
// Depends on xsed_pkg.
module xsed_marks (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [xsed_pkg::MARK_AW-1:0]  rd_addr,
  input  xsed_pkg::mark_wr_t            wr,
  output logic                          rd_mark,
  output logic                          clearing
);

  logic                         mem [xsed_pkg::MAX_OBJECTS];
  logic                         rd_r;
  logic                         clearing_r;
  logic [xsed_pkg::MARK_AW-1:0] clr_r;

  // Sweep every slot once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Write port: clearing sweep, else set the mark of a stored entry
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= 1'b0;
    end else if (wr.en) begin
      mem[wr.addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_mark  = rd_r;
  assign clearing = clearing_r;

endmodule

FILE: rtl/xsed_emit.sv
// Result stage: resolves the accepted flag from the mark read, updates the
// mark and holds the output word. Depends on xsed_pkg.
module xsed_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  xsed_pkg::res_t      res,
  input  logic                rd_mark,
  input  logic                out_ready,
  output logic                room,
  output xsed_pkg::mark_wr_t  mark_wr,
  output logic                out_valid,
  output xsed_pkg::res_t      out_res,
  output logic                out_accepted
);

  xsed_pkg::res_t s1_r;
  logic           s1_valid_r;
  logic           s1_hit_r;
  logic           s1_move;
  logic           s1_acc;
  xsed_pkg::res_t out_r;
  logic           out_acc_r;
  logic           out_valid_r;

  assign s1_move = s1_valid_r && (!out_valid_r || out_ready);
  assign room    = !s1_valid_r || s1_move;

  // Slot is free unless the memory or the write at load time says otherwise
  assign s1_acc = (s1_r.kind == xsed_pkg::KIND_ENTRY) && s1_r.in_range &&
                  !(rd_mark || s1_hit_r);

  assign mark_wr.en   = s1_move && s1_acc && (s1_r.etype != xsed_pkg::TYPE_UNKNOWN);
  assign mark_wr.addr = s1_r.mark_addr;

  // Hold the word whose mark read is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ld) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture payload and catch a write to the same slot on the same edge
  always_ff @(posedge clk) begin
    if (ld) begin
      s1_r     <= res;
      s1_hit_r <= mark_wr.en && (mark_wr.addr == res.mark_addr);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r     <= s1_r;
      out_acc_r <= s1_acc;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res      = out_r;
  assign out_accepted = out_acc_r;

endmodule

FILE: rtl/xref_stream_entry_decoder_top.sv
// Top level of the cross-reference stream entry decoder.
// Depends on xsed_pkg, xsed_cfg_regs, xsed_parse, xsed_marks and xsed_emit.
//
// Usage:
//   in_*   : one command word per handshake; in_tuser carries the command
//            (section start, data byte, end of stream), in_tdata its operands.
//   out_*  : one result word per entry, section start or end of stream;
//            out_tuser carries the result kind, out_tdata the entry fields.
//   cfg_*  : register writes (type, offset and generation byte widths, table
//            length); cfg_ready is always high. Write only while idle.
// Throughput: one input word per cycle, sustained, while the output is drained.
// Pipeline: an accepted word is registered in the mark-read stage, alongside the
//   registered read of the filled-mark memory, and then in the output register.
// Reset: clears all control state, then sweeps the 65536-entry filled-mark
//   memory one slot per cycle; in_tready stays low until the sweep ends.
// Stall: when out_tready is low the output word holds; one more word may sit
//   in the mark-read stage, after which in_tready drops until space frees up.
module xref_stream_entry_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // data_byte[7:0], first_index[23:8], entry_count[40:24]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // entry_index[15:0], entry_type[17:16],
                                  // entry_offset[49:18], entry_generation[81:50],
                                  // accepted[82]
  output logic [2:0]  out_tuser,  // kind[2:0]
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  xsed_pkg::cfg_t     cfg;
  xsed_pkg::res_t     res;
  xsed_pkg::res_t     out_res;
  xsed_pkg::mark_wr_t mark_wr;
  logic               res_valid;
  logic               take;
  logic               room;
  logic               clearing;
  logic               rd_mark;
  logic               out_accepted;

  assign cfg_ready = 1'b1;
  assign in_tready = room && !clearing;
  assign take      = in_tvalid && in_tready;

  xsed_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  xsed_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .take        (take),
    .cmd         (in_tuser),
    .data_byte   (in_tdata[7:0]),
    .first_index (in_tdata[23:8]),
    .entry_count (in_tdata[40:24]),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Read the slot mark only for entries that land inside the table
  xsed_marks u_marks (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (take && res_valid && res.kind == xsed_pkg::KIND_ENTRY && res.in_range),
    .rd_addr  (res.mark_addr),
    .wr       (mark_wr),
    .rd_mark  (rd_mark),
    .clearing (clearing)
  );

  xsed_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld           (take && res_valid),
    .res          (res),
    .rd_mark      (rd_mark),
    .out_ready    (out_tready),
    .room         (room),
    .mark_wr      (mark_wr),
    .out_valid    (out_tvalid),
    .out_res      (out_res),
    .out_accepted (out_accepted)
  );

  // Pack the result word
  assign out_tuser = out_res.kind;
  assign out_tdata = {5'b0, out_accepted, out_res.gen, out_res.offset,
                      out_res.etype, out_res.idx};

endmodule
